// ===== design/dbpl_pkg.sv =====
package dbpl_pkg;

  // Table size limits
  localparam int ENTRIES_DEF = 128;
  localparam int CNT_W       = 8;   // holds 0..128 (scan index, live count, packed entries)
  localparam int IDX_FLD_W   = 7;   // entry index field
  localparam int BLK_W       = 7;   // block count and block length, 0..64
  localparam int MAX_BLOCKS  = 64;

  // Register field widths and reset values
  localparam int MBE_W = 7;
  localparam int RW_W  = 5;
  localparam int HW_W  = 3;
  localparam logic [MBE_W-1:0] MBE_RESET = MBE_W'(16);
  localparam logic [RW_W-1:0]  RW_RESET  = RW_W'(8);
  localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(3);
  localparam logic [MBE_W-1:0] MBE_MAX   = MBE_W'(64);
  localparam logic [RW_W-1:0]  RW_MAX    = RW_W'(16);
  localparam logic [HW_W-1:0]  HW_MAX    = HW_W'(4);

  // APB register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_MAX_BLOCK = 2'd0;
  localparam logic [1:0] REG_RECORD    = 2'd1;
  localparam logic [1:0] REG_HEADER    = 2'd2;

  // Item function codes
  localparam logic [1:0] FUNC_MARK  = 2'd0;
  localparam logic [1:0] FUNC_FLUSH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Shared multiply-accumulate unit
  localparam int MAC_A_W   = 8;
  localparam int MAC_B_W   = 5;
  localparam int MAC_ACC_W = 12;

  // Result field widths
  localparam int DST_W  = 11;
  localparam int SRC_W  = 12;
  localparam int SIZE_W = 11;

  typedef struct packed {
    logic                 load;   // start a new product
    logic                 accum;  // add product to the running sum
    logic [MAC_A_W-1:0]   a;
    logic [MAC_B_W-1:0]   b;
  } mac_req_t;

  typedef struct packed {
    logic                 set_en;
    logic [IDX_FLD_W-1:0] set_idx;
    logic                 clr_all;
    logic                 clr_low;    // clear entries below clr_limit
    logic [CNT_W-1:0]     clr_limit;
  } bm_ctrl_t;

endpackage

// ===== design/dbpl_bitmap.sv =====
module dbpl_bitmap #(
  parameter int ENTRIES = dbpl_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dbpl_pkg::bm_ctrl_t        ctrl,
  input  logic [$clog2(ENTRIES)-1:0] rd_idx,
  output logic                      rd_bit
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [ENTRIES-1:0] bits;

  assign rd_bit = bits[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (ctrl.clr_all) begin
      bits <= '0;
    end else if (ctrl.clr_low) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if (dbpl_pkg::CNT_W'(e) < ctrl.clr_limit) begin
          bits[e] <= 1'b0;
        end
      end
    end else if (ctrl.set_en) begin
      bits[ctrl.set_idx[IDX_W-1:0]] <= 1'b1;
    end
  end

endmodule

// ===== design/dbpl_mac.sv =====
module dbpl_mac (
  input  logic                                clk,
  input  dbpl_pkg::mac_req_t                  req,
  output logic [dbpl_pkg::MAC_ACC_W-1:0]      acc
);

  logic [dbpl_pkg::MAC_A_W+dbpl_pkg::MAC_B_W-1:0] prod;

  assign prod = req.a * req.b;

  // hold the sum when idle
  always_ff @(posedge clk) begin
    if (req.load) begin
      acc <= (req.accum ? acc : '0) + dbpl_pkg::MAC_ACC_W'(prod);
    end
  end

endmodule

// ===== design/dirty_bitmap_patch_list_builder.sv =====
// Mark and clear transactions are accepted back to back.
// Flush: count blocks over min(live_count, ENTRIES) entries, stopping at the block cap, then an
// emit pass that per block closes the run, takes four steps on the shared multiplier, loads and
// offers the result (holding while the output stalls), then the bitmap is cleared.
// An empty flush offers its result right after the count; item_stall is high until done.
// rst (synchronous) clears the dirty bitmap, idles the sequencer and loads register defaults.
module dirty_bitmap_patch_list_builder #(
  parameter int ENTRIES = dbpl_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dbpl_pkg::PADDR_W-1:0]      paddr,
  input  logic [dbpl_pkg::PDATA_W-1:0]      pwdata,
  output logic [dbpl_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        func,
  input  logic [dbpl_pkg::IDX_FLD_W-1:0]    entry_index,
  input  logic [dbpl_pkg::CNT_W-1:0]        live_count,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              block_valid,
  output logic [dbpl_pkg::DST_W-1:0]        dst_word,
  output logic [dbpl_pkg::SRC_W-1:0]        src_word,
  output logic [dbpl_pkg::SIZE_W-1:0]       size_words,
  output logic [dbpl_pkg::BLK_W-1:0]        block_total,
  output logic                              last
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [dbpl_pkg::CNT_W-1:0] ENTRIES_CNT = dbpl_pkg::CNT_W'(ENTRIES);
  localparam logic [dbpl_pkg::BLK_W-1:0] MAX_BLK = dbpl_pkg::BLK_W'(dbpl_pkg::MAX_BLOCKS);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_COUNT    = 9'b000000010,  // first pass: count blocks, find cap point
    S_SCAN     = 9'b000000100,  // second pass: walk the bitmap, close blocks
    S_MUL_DST  = 9'b000001000,
    S_MUL_SIZE = 9'b000010000,
    S_MUL_HDR  = 9'b000100000,
    S_MUL_PACK = 9'b001000000,
    S_EMIT     = 9'b010000000,  // result register loaded, wait for the taker
    S_FINISH   = 9'b100000000   // clear the bitmap
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------------
  // Configuration registers (raw values read back; saturated copies used)
  // ---------------------------------------------------------------------------
  logic [dbpl_pkg::MBE_W-1:0] max_block_entries;
  logic [dbpl_pkg::RW_W-1:0]  record_words;
  logic [dbpl_pkg::HW_W-1:0]  header_words_per_block;
  logic [dbpl_pkg::MBE_W-1:0] maxb;
  logic [dbpl_pkg::RW_W-1:0]  rw;
  logic [dbpl_pkg::HW_W-1:0]  hw;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_entries      <= dbpl_pkg::MBE_RESET;
      record_words           <= dbpl_pkg::RW_RESET;
      header_words_per_block <= dbpl_pkg::HW_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        dbpl_pkg::REG_MAX_BLOCK: max_block_entries <= pwdata[dbpl_pkg::MBE_W-1:0];
        dbpl_pkg::REG_RECORD:    record_words <= pwdata[dbpl_pkg::RW_W-1:0];
        dbpl_pkg::REG_HEADER:    header_words_per_block <= pwdata[dbpl_pkg::HW_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dbpl_pkg::REG_MAX_BLOCK: prdata = dbpl_pkg::PDATA_W'(max_block_entries);
      dbpl_pkg::REG_RECORD:    prdata = dbpl_pkg::PDATA_W'(record_words);
      dbpl_pkg::REG_HEADER:    prdata = dbpl_pkg::PDATA_W'(header_words_per_block);
      default:                 prdata = '0;
    endcase
  end

  // Saturate each register into its legal range; zero counts as one.
  always_comb begin
    if (max_block_entries == '0)                   maxb = dbpl_pkg::MBE_W'(1);
    else if (max_block_entries > dbpl_pkg::MBE_MAX) maxb = dbpl_pkg::MBE_MAX;
    else                                           maxb = max_block_entries;
    if (record_words == '0)                        rw = dbpl_pkg::RW_W'(1);
    else if (record_words > dbpl_pkg::RW_MAX)      rw = dbpl_pkg::RW_MAX;
    else                                           rw = record_words;
    if (header_words_per_block == '0)              hw = dbpl_pkg::HW_W'(1);
    else if (header_words_per_block > dbpl_pkg::HW_MAX) hw = dbpl_pkg::HW_MAX;
    else                                           hw = header_words_per_block;
  end

  // ---------------------------------------------------------------------------
  // Scan registers
  // ---------------------------------------------------------------------------
  logic [dbpl_pkg::CNT_W-1:0]     scan_i;     // current entry
  logic [dbpl_pkg::CNT_W-1:0]     limit;      // scan end: live count, or the cap point
  logic                           open;       // previous entry was dirty and in the run
  logic                           have_blk;   // a run is pending emission (second pass)
  logic [dbpl_pkg::IDX_FLD_W-1:0] run_start;
  logic [dbpl_pkg::BLK_W-1:0]     run_len;
  logic [dbpl_pkg::BLK_W-1:0]     nblk;
  logic                           capped;
  logic [dbpl_pkg::BLK_W-1:0]     blk_k;      // blocks already emitted
  logic [dbpl_pkg::CNT_W-1:0]     packed_cnt; // dirty entries before the current block
  logic [dbpl_pkg::IDX_FLD_W-1:0] blk_start;
  logic [dbpl_pkg::BLK_W-1:0]     blk_len;
  logic                           empty_flush;

  logic                           item_acc;
  logic                           scan_end;
  logic                           cur_bit;
  logic                           extend;
  logic [dbpl_pkg::CNT_W-1:0]     live_eff;
  logic                           mark_ok;

  dbpl_pkg::bm_ctrl_t                bm_ctrl;
  dbpl_pkg::mac_req_t                mac_req;
  logic [dbpl_pkg::MAC_ACC_W-1:0]    mac_acc;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign scan_end   = (scan_i == limit);
  assign extend     = open && (run_len < dbpl_pkg::BLK_W'(maxb));
  assign live_eff   = (live_count > ENTRIES_CNT) ? ENTRIES_CNT : live_count;
  assign mark_ok    = ({1'b0, entry_index} < ENTRIES_CNT);

  dbpl_bitmap #(
    .ENTRIES (ENTRIES)
  ) u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (bm_ctrl),
    .rd_idx (scan_i[IDX_W-1:0]),
    .rd_bit (cur_bit)
  );

  dbpl_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  // Bitmap updates: mark and clear straight from the item, flush clear at the end.
  always_comb begin
    bm_ctrl           = '0;
    bm_ctrl.set_idx   = entry_index;
    bm_ctrl.clr_limit = limit;
    if (item_acc && func == dbpl_pkg::FUNC_MARK) bm_ctrl.set_en = mark_ok;
    if (item_acc && func == dbpl_pkg::FUNC_CLEAR) bm_ctrl.clr_all = 1'b1;
    if (state == S_FINISH) begin
      // a capped flush keeps the entries past the cap dirty
      bm_ctrl.clr_all = !capped;
      bm_ctrl.clr_low = capped;
    end
  end

  // Multiplier schedule: dst = start*rw, size = len*rw, src = nblk*hw + packed*rw.
  always_comb begin
    mac_req = '0;
    unique case (state)
      S_MUL_DST: begin
        mac_req.load = 1'b1;
        mac_req.a    = dbpl_pkg::MAC_A_W'(blk_start);
        mac_req.b    = rw;
      end
      S_MUL_SIZE: begin
        mac_req.load = 1'b1;
        mac_req.a    = dbpl_pkg::MAC_A_W'(blk_len);
        mac_req.b    = rw;
      end
      S_MUL_HDR: begin
        mac_req.load = 1'b1;
        mac_req.a    = dbpl_pkg::MAC_A_W'(nblk);
        mac_req.b    = dbpl_pkg::MAC_B_W'(hw);
      end
      S_MUL_PACK: begin
        mac_req.load  = 1'b1;
        mac_req.accum = 1'b1;
        mac_req.a     = packed_cnt;
        mac_req.b     = rw;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_acc && func == dbpl_pkg::FUNC_FLUSH) begin
            scan_i      <= '0;
            limit       <= live_eff;
            open        <= 1'b0;
            run_len     <= '0;
            nblk        <= '0;
            capped      <= 1'b0;
            empty_flush <= 1'b0;
            state       <= S_COUNT;
          end
        end

        S_COUNT: begin
          if (scan_end) begin
            if (nblk == '0) begin
              // nothing dirty: one invalid result, bitmap untouched
              block_valid  <= 1'b0;
              dst_word     <= '0;
              src_word     <= '0;
              size_words   <= '0;
              block_total  <= '0;
              last         <= 1'b1;
              empty_flush  <= 1'b1;
              result_valid <= 1'b1;
              state        <= S_EMIT;
            end else begin
              scan_i     <= '0;
              open       <= 1'b0;
              have_blk   <= 1'b0;
              blk_k      <= '0;
              packed_cnt <= '0;
              state      <= S_SCAN;
            end
          end else if (!cur_bit) begin
            open   <= 1'b0;
            scan_i <= scan_i + 1'b1;
          end else if (extend) begin
            run_len <= run_len + 1'b1;
            scan_i  <= scan_i + 1'b1;
          end else if (nblk == MAX_BLK) begin
            // block budget spent: stop both passes here
            capped <= 1'b1;
            limit  <= scan_i;
          end else begin
            nblk    <= nblk + 1'b1;
            run_len <= dbpl_pkg::BLK_W'(1);
            open    <= 1'b1;
            scan_i  <= scan_i + 1'b1;
          end
        end

        S_SCAN: begin
          if (scan_end) begin
            if (have_blk) begin
              blk_start <= run_start;
              blk_len   <= run_len;
              have_blk  <= 1'b0;
              state     <= S_MUL_DST;
            end else begin
              state <= S_FINISH;
            end
          end else if (!cur_bit) begin
            open   <= 1'b0;
            scan_i <= scan_i + 1'b1;
          end else if (have_blk && extend) begin
            run_len <= run_len + 1'b1;
            scan_i  <= scan_i + 1'b1;
          end else if (have_blk) begin
            // a new run starts here: emit the pending one, revisit this entry
            blk_start <= run_start;
            blk_len   <= run_len;
            have_blk  <= 1'b0;
            state     <= S_MUL_DST;
          end else begin
            run_start <= scan_i[dbpl_pkg::IDX_FLD_W-1:0];
            run_len   <= dbpl_pkg::BLK_W'(1);
            open      <= 1'b1;
            have_blk  <= 1'b1;
            scan_i    <= scan_i + 1'b1;
          end
        end

        S_MUL_DST: begin
          state <= S_MUL_SIZE;
        end

        S_MUL_SIZE: begin
          dst_word <= mac_acc[dbpl_pkg::DST_W-1:0];
          state    <= S_MUL_HDR;
        end

        S_MUL_HDR: begin
          size_words <= mac_acc[dbpl_pkg::SIZE_W-1:0];
          state      <= S_MUL_PACK;
        end

        S_MUL_PACK: begin
          // sum lands in the accumulator next cycle; load it in the emit state
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (!result_valid) begin
            src_word     <= mac_acc;
            block_valid  <= 1'b1;
            block_total  <= nblk;
            last         <= (blk_k + 1'b1 == nblk);
            result_valid <= 1'b1;
          end else if (!result_stall) begin
            result_valid <= 1'b0;
            if (empty_flush) begin
              state <= S_IDLE;
            end else begin
              packed_cnt <= packed_cnt + dbpl_pkg::CNT_W'(blk_len);
              blk_k      <= blk_k + 1'b1;
              state      <= last ? S_FINISH : S_SCAN;
            end
          end
        end

        S_FINISH: begin
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/dbpl_checker.sv =====
module dbpl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic                           block_valid,
  input logic [dbpl_pkg::DST_W-1:0]     dst_word,
  input logic [dbpl_pkg::SRC_W-1:0]     src_word,
  input logic [dbpl_pkg::SIZE_W-1:0]    size_words,
  input logic [dbpl_pkg::BLK_W-1:0]     block_total,
  input logic                           last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(dst_word) &&
      $stable(src_word) && $stable(size_words) && $stable(last))
    else $error("stalled result changed");

  // no new item is taken while a result is on offer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item channel open while a result is pending");

  // an empty flush gives one all-zero final result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !block_valid |-> last && block_total == '0 &&
      dst_word == '0 && src_word == '0 && size_words == '0)
    else $error("malformed empty flush result");

  // a real block has a size and a nonzero block count
  a_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && block_valid |-> size_words != '0 && block_total != '0)
    else $error("block result with zero size or count");

  // reset leaves the block idle
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

endmodule

bind dirty_bitmap_patch_list_builder dbpl_checker u_dbpl_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .block_valid  (block_valid),
  .dst_word     (dst_word),
  .src_word     (src_word),
  .size_words   (size_words),
  .block_total  (block_total),
  .last         (last)
);

// ===== bench/dirty_bitmap_patch_checker.sv =====
`timescale 1ns / 100ps

module dirty_bitmap_patch_checker #(
  parameter int ENTRIES = dbpl_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [dbpl_pkg::PADDR_W-1:0]      paddr,
  input  logic [dbpl_pkg::PDATA_W-1:0]      pwdata,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic [1:0]                        func,
  input  logic [dbpl_pkg::IDX_FLD_W-1:0]    entry_index,
  input  logic [dbpl_pkg::CNT_W-1:0]        live_count,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic                              block_valid,
  input  logic [dbpl_pkg::DST_W-1:0]        dst_word,
  input  logic [dbpl_pkg::SRC_W-1:0]        src_word,
  input  logic [dbpl_pkg::SIZE_W-1:0]       size_words,
  input  logic [dbpl_pkg::BLK_W-1:0]        block_total,
  input  logic                              last,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);

  import dbpl_pkg::*;

  typedef struct packed {
    logic              blk_valid;
    logic [DST_W-1:0]  dst;
    logic [SRC_W-1:0]  src;
    logic [SIZE_W-1:0] size_w;
    logic [BLK_W-1:0]  total;
    logic              is_last;
  } patch_t;

  patch_t             expected_patches[$];
  logic [ENTRIES-1:0] dirty_map;
  logic [MBE_W-1:0]   max_block_q;
  logic [RW_W-1:0]    record_q;
  logic [HW_W-1:0]    header_q;
  int                 errors;
  int                 checked_n;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Append one predicted patch at the tail of the queue.
  function automatic void enqueue_patch(input patch_t p);
    expected_patches = {expected_patches, p};
  endfunction

  // Walk the bitmap, coalesce dirty runs into copy blocks and queue one patch per block.
  task automatic predict_flush(input int live_in);
    int     maxb, rw, hw, live, nblk, packed_n, i, j, k;
    int     bstart[MAX_BLOCKS];
    int     blen[MAX_BLOCKS];
    bit     capped;
    patch_t p;
    maxb     = clamp_int(int'(max_block_q), 1, int'(MBE_MAX));
    rw       = clamp_int(int'(record_q), 1, int'(RW_MAX));
    hw       = clamp_int(int'(header_q), 1, int'(HW_MAX));
    live     = (live_in > ENTRIES) ? ENTRIES : live_in;
    nblk     = 0;
    packed_n = 0;
    capped   = 1'b0;
    for (i = 0; i < live; i++) begin
      if (!dirty_map[i]) continue;
      if (nblk > 0 && bstart[nblk-1] + blen[nblk-1] == i && blen[nblk-1] < maxb) begin
        blen[nblk-1]++;
        continue;
      end
      if (nblk == MAX_BLOCKS) begin
        capped = 1'b1;
        break;
      end
      bstart[nblk] = i;
      blen[nblk]   = 1;
      nblk++;
    end
    // nothing dirty: a single empty patch, bitmap left alone
    if (nblk == 0) begin
      p         = '0;
      p.is_last = 1'b1;
      enqueue_patch(p);
      return;
    end
    for (k = 0; k < nblk; k++) begin
      p.blk_valid = 1'b1;
      p.dst       = DST_W'(bstart[k] * rw);
      p.src       = SRC_W'(nblk * hw + packed_n * rw);
      p.size_w    = SIZE_W'(blen[k] * rw);
      p.total     = BLK_W'(nblk);
      p.is_last   = (k == nblk - 1);
      enqueue_patch(p);
      packed_n += blen[k];
    end
    // a capped scan only retires what it emitted
    if (capped) begin
      for (k = 0; k < nblk; k++)
        for (j = 0; j < blen[k]; j++)
          dirty_map[bstart[k] + j] = 1'b0;
    end else begin
      dirty_map = '0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    patch_t want;
    if (rst) begin
      dirty_map   = '0;
      max_block_q = MBE_RESET;
      record_q    = RW_RESET;
      header_q    = HW_RESET;
      expected_patches.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAX_BLOCK: max_block_q = pwdata[MBE_W-1:0];
          REG_RECORD:    record_q    = pwdata[RW_W-1:0];
          REG_HEADER:    header_q    = pwdata[HW_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        case (func)
          FUNC_MARK:  if (entry_index < ENTRIES) dirty_map[entry_index] = 1'b1;
          FUNC_FLUSH: predict_flush(int'(live_count));
          FUNC_CLEAR: dirty_map = '0;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        checked_n++;
        if (expected_patches.size() == 0) begin
          $display("%0t: unexpected patch, expected none actual dst %0d src %0d size %0d",
                   $time, dst_word, src_word, size_words);
          errors++;
        end else begin
          want = expected_patches.pop_front();
          check_field("block_valid", want.blk_valid, block_valid);
          check_field("dst_word", want.dst, dst_word);
          check_field("src_word", want.src, src_word);
          check_field("size_words", want.size_w, size_words);
          check_field("block_total", want.total, block_total);
          check_field("last", want.is_last, last);
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_patches.size();
    checked    <= checked_n;
  end

endmodule

// ===== bench/dirty_bitmap_patch_list_builder_tb.sv =====
`timescale 1ns / 100ps

module dirty_bitmap_patch_list_builder_tb;

  import dbpl_pkg::*;

  // func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 400;
  // quiet cycles after the last patch so a trailing mark or clear settles
  localparam int SETTLE_CYCLES = 16;
  // worst case: every flush at 64 blocks, each patch held by the longest stall
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [PDATA_W-1:0]     pwdata  = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  logic                   item_valid  = 1'b0;
  logic                   item_stall;
  logic [1:0]             func        = FUNC_MARK;
  logic [IDX_FLD_W-1:0]   entry_index = '0;
  logic [CNT_W-1:0]       live_count  = '0;

  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   block_valid;
  logic [DST_W-1:0]       dst_word;
  logic [SRC_W-1:0]       src_word;
  logic [SIZE_W-1:0]      size_words;
  logic [BLK_W-1:0]       block_total;
  logic                   last;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping and per-phase idling switches
  int items_sent   = 0;
  int flushes_sent = 0;
  int phases_run   = 0;
  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  int stall_left   = 0;
  int stall_roll   = 0;

  always #1 clk = ~clk;

  dirty_bitmap_patch_list_builder u_dut (.*);

  dirty_bitmap_patch_checker u_checker (.*);

  // Result-side backpressure: mostly open, short bursts of stall, now and then a long hold.
  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        result_stall <= 1'b0;
      end else if (stall_roll < 93) begin
        stall_left = $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        result_stall <= 1'b1;
      end
    end
  end

  // Present one transaction and hold it until the block takes it. Called at a rising
  // edge; any idle gap comes first so that a back-to-back valid is never dropped and
  // raised again in one step.
  task automatic send_item(input logic [1:0] f, input int idx, input int live);
    int gap;
    int roll;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else                gap = $urandom_range(6, 30);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    func        <= f;
    entry_index <= idx[IDX_FLD_W-1:0];
    live_count  <= live[CNT_W-1:0];
    do @(posedge clk); while (item_stall);
    if (f != FUNC_UNUSED) items_sent++;
    if (f == FUNC_FLUSH) flushes_sent++;
  endtask

  // Drop valid and hold off until every predicted patch has come back, then let the
  // block finish any mark or clear still in flight.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready, then drop back to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register with junk in the unused upper bits.
  task automatic write_field(input logic [1:0] idx, input int val, input int width);
    logic [PDATA_W-1:0] mask;
    mask = (32'd1 << width) - 32'd1;
    write_reg(idx, ($urandom & ~mask) | (val & mask));
  endtask

  // Pick register settings per phase: saturating lows, saturating highs, legal
  // extremes, then random values mostly inside the legal range.
  task automatic configure(input int phase);
    int mbe, rw, hw;
    case (phase)
      0: begin mbe = 0;   rw = 0;  hw = 0; end
      1: begin mbe = 127; rw = 31; hw = 7; end
      2: begin mbe = 64;  rw = 16; hw = 4; end
      3: begin mbe = 1;   rw = 1;  hw = 1; end
      default: begin
        mbe = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 127) : $urandom_range(1, 24);
        rw  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 31)  : $urandom_range(1, 16);
        hw  = $urandom_range(0, 7);
      end
    endcase
    // later phases sometimes keep a register from the previous phase
    if (phase < 4 || $urandom_range(0, 3) != 0) write_field(REG_MAX_BLOCK, mbe, MBE_W);
    if (phase < 4 || $urandom_range(0, 3) != 0) write_field(REG_RECORD, rw, RW_W);
    if (phase < 4 || $urandom_range(0, 3) != 0) write_field(REG_HEADER, hw, HW_W);
  endtask

  // Scan length for a flush: mostly the whole table, some partial, some oversize.
  function automatic int pick_live();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 128;
    if (roll < 80) return $urandom_range(0, 128);
    if (roll < 90) return $urandom_range(129, 255);
    return $urandom_range(0, 255);
  endfunction

  // Stray transaction: any func with any fields.
  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 255));
  endtask

  // One random batch: a few dirty runs, a scatter of marks, or plain noise, then
  // usually a flush.
  task automatic random_batch();
    int kind, runs, start, len, n, r, k;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) send_item(FUNC_CLEAR, $urandom_range(0, 127), 0);
    if (kind < 50) begin
      runs = $urandom_range(1, 4);
      for (r = 0; r < runs; r++) begin
        start = $urandom_range(0, 127);
        len   = $urandom_range(1, 24);
        for (k = 0; k < len && start + k < ENTRIES_DEF; k++) begin
          send_item(FUNC_MARK, start + k, $urandom_range(0, 255));
          if ($urandom_range(0, 15) == 0) send_noise();
        end
      end
      send_item(FUNC_FLUSH, $urandom_range(0, 127), pick_live());
    end else if (kind < 75) begin
      n = $urandom_range(1, 16);
      for (k = 0; k < n; k++) send_item(FUNC_MARK, $urandom_range(0, 127), $urandom_range(0, 255));
      send_item(FUNC_FLUSH, $urandom_range(0, 127), pick_live());
    end else begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) send_noise();
      if ($urandom_range(0, 2) != 0) send_item(FUNC_FLUSH, $urandom_range(0, 127), pick_live());
    end
  endtask

  // Directed opening under reset register values.
  task automatic directed_items();
    send_item(FUNC_FLUSH, 0, 128);     // empty bitmap
    send_item(FUNC_MARK, 0, 0);
    send_item(FUNC_MARK, 127, 255);
    send_item(FUNC_MARK, 1, 0);
    send_item(FUNC_MARK, 126, 0);
    send_item(FUNC_FLUSH, 127, 255);   // oversize live count, both table ends
    send_item(FUNC_MARK, 5, 0);
    send_item(FUNC_UNUSED, 6, 255);    // must be ignored
    send_item(FUNC_FLUSH, 0, 5);       // dirty entry outside the scan: empty, bit kept
    send_item(FUNC_FLUSH, 0, 6);
    send_item(FUNC_MARK, 10, 0);
    send_item(FUNC_CLEAR, 0, 0);
    send_item(FUNC_FLUSH, 0, 128);     // cleared: empty
    send_item(FUNC_MARK, 3, 0);
    send_item(FUNC_FLUSH, 0, 0);       // zero live count: empty, bit kept
    send_item(FUNC_FLUSH, 0, 128);
    send_item(FUNC_MARK, 100, 0);
    send_item(FUNC_MARK, 2, 0);
    send_item(FUNC_FLUSH, 0, 50);      // entry 100 beyond the scan is still wiped
    send_item(FUNC_FLUSH, 0, 128);     // so this one is empty
  endtask

  initial begin : stimulus
    int phase;
    int directed_n;
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    directed_n = items_sent;

    phase = 0;
    while (items_sent - directed_n < RANDOM_ITEMS) begin
      // every third phase runs with no idling on either side
      wait_idle();
      gaps_on   = (phase % 3 != 2);
      stalls_on = (phase % 3 != 2);
      configure(phase);
      if (phase == 0) begin
        // single-entry blocks: 70 dirty entries overflow the 64-block cap
        for (k = 0; k < 70; k++) send_item(FUNC_MARK, k, $urandom_range(0, 255));
        send_item(FUNC_FLUSH, 0, 128);
        send_item(FUNC_FLUSH, 0, 255);   // leftovers from the capped scan
        send_item(FUNC_FLUSH, 0, 128);
      end else if (phase == 1) begin
        // widest blocks and records: one full 64-entry block plus a tail
        for (k = 69; k >= 0; k--) send_item(FUNC_MARK, k, $urandom_range(0, 255));
        send_item(FUNC_FLUSH, 0, 128);
      end
      repeat ($urandom_range(2, 4)) random_batch();
      phase++;
    end
    phases_run = phase;

    wait_idle();
    $display("ran %0d transactions (%0d flushes) over %0d register phases", items_sent,
             flushes_sent, phases_run);
    $display("checked %0d patch results, including capped, empty and saturated cases",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
